>>> design/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg: shared definitions for the text console teletype
// Action codes, default screen geometry and payload widths.
// ----------------------------------------------------------------------------
package ttc_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] BLANK_CHAR = 8'h20;

	// action codes carried in s_tuser
	localparam logic [1:0] ACT_PUT  = 2'd0;
	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	// result field widths
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;

endpackage

>>> design/text_console_teletype_core.sv
// ----------------------------------------------------------------------------
// text_console_teletype_core: text-mode screen with a cursor
// Put, set-cursor and read actions on a COLUMNS x ROWS character store.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  s_*     | in  | s_tvalid / s_tready  | tuser: action; tdata: char, col, row
//  m_*     | out | m_tvalid / m_tready  | tdata: col, row, cell char, scrolled
//
//  Put (no wrap on the last row) and set load the output register on accept;
//  a read goes through address latch, registered RAM read and result load.
//  A put that wraps on the last row scrolls: rows are copied up by one row,
//  then the bottom row is filled with spaces, through the single RAM port pair.
//  After reset all COLUMNS*ROWS cells (2000 by default) are cleared to spaces,
//  with s_tready low.
//  The output register takes a new result while the old one drains.
// ----------------------------------------------------------------------------
module text_console_teletype_core #(
	parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
	parameter int ROWS    = ttc_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] col_in, [23:16] row_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [6:0] cursor_col, [11:7] cursor_row,
	                               // [19:12] cell_char, [20] scrolled, rest zero
);

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_ROW0 = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);

	localparam logic [2:0] ST_FILL = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_COPY = 3'd2;
	localparam logic [2:0] ST_RD1  = 3'd3;
	localparam logic [2:0] ST_RD2  = 3'd4;

	logic [2:0]       state_q;
	logic [AW-1:0]    ptr_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;

	logic          wr_en_q;
	logic          wr_from_rd_q;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_data_q;
	logic [7:0]    rd_data;
	logic [7:0]    ram_wdata;

	logic                 m_tvalid_q;
	logic [COL_W-1:0]     res_col_q;
	logic [ROW_W-1:0]     res_row_q;
	logic [7:0]           res_cell_q;
	logic                 res_scroll_q;

	logic [1:0]       in_act;
	logic [7:0]       in_char;
	logic [7:0]       in_col;
	logic [7:0]       in_row;
	logic [COL_W-1:0] clamp_col;
	logic [ROW_W-1:0] clamp_row;
	logic [AW-1:0]    cur_idx;
	logic [AW-1:0]    req_idx;
	logic             accept;
	logic             col_wrap;
	logic             do_scroll;

	assign in_act  = s_tuser;
	assign in_char = s_tdata[7:0];
	assign in_col  = s_tdata[15:8];
	assign in_row  = s_tdata[23:16];

	always_comb begin
		clamp_col = ({1'b0, in_col} >= 9'(COLUMNS)) ? COL_MAX : COL_W'(in_col);
		clamp_row = ({1'b0, in_row} >= 9'(ROWS)) ? ROW_MAX : ROW_W'(in_row);
	end

	assign cur_idx = AW'(AW'(cur_row_q) * ROW_STEP) + AW'(cur_col_q);
	assign req_idx = AW'(AW'(clamp_row) * ROW_STEP) + AW'(clamp_col);

	assign s_tready  = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign col_wrap  = (cur_col_q == COL_MAX);
	assign do_scroll = accept && (in_act == ttc_pkg::ACT_PUT) && col_wrap &&
	                   (cur_row_q == ROW_MAX);

	// copy writes take the registered read data of the RAM
	assign ram_wdata = wr_from_rd_q ? rd_data : wr_data_q;

	ttc_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (wr_en_q),
		.waddr(wr_addr_q),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(rd_data)
	);

	// sequencer, cursor and write stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			ptr_q        <= '0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			wr_en_q      <= 1'b0;
			wr_from_rd_q <= 1'b0;
		end else begin
			wr_en_q      <= 1'b0;
			wr_from_rd_q <= 1'b0;
			case (state_q)
				ST_FILL: begin
					wr_en_q <= 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (in_act)
							ttc_pkg::ACT_PUT: begin
								wr_en_q <= 1'b1;
								if (col_wrap) begin
									cur_col_q <= '0;
									if (cur_row_q == ROW_MAX) begin
										state_q <= ST_COPY;
										ptr_q   <= ROW_STEP;
									end else begin
										cur_row_q <= cur_row_q + ROW_W'(1);
									end
								end else begin
									cur_col_q <= cur_col_q + COL_W'(1);
								end
							end
							ttc_pkg::ACT_SET: begin
								cur_col_q <= clamp_col;
								cur_row_q <= clamp_row;
							end
							ttc_pkg::ACT_READ: begin
								state_q <= ST_RD1;
								ptr_q   <= req_idx;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					wr_en_q      <= 1'b1;
					wr_from_rd_q <= 1'b1;
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_FILL;
						ptr_q   <= LAST_ROW0;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// write stage payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FILL: begin
				wr_addr_q <= ptr_q;
				wr_data_q <= ttc_pkg::BLANK_CHAR;
			end
			ST_COPY: begin
				wr_addr_q <= ptr_q - ROW_STEP;
			end
			default: begin
				wr_addr_q <= cur_idx;
				wr_data_q <= in_char;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((accept && (in_act != ttc_pkg::ACT_READ)) || (state_q == ST_RD2)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD2) begin
			res_col_q    <= cur_col_q;
			res_row_q    <= cur_row_q;
			res_cell_q   <= rd_data;
			res_scroll_q <= 1'b0;
		end else if (accept) begin
			res_cell_q   <= 8'h00;
			res_scroll_q <= do_scroll;
			res_col_q    <= cur_col_q;
			res_row_q    <= cur_row_q;
			case (in_act)
				ttc_pkg::ACT_PUT: begin
					if (col_wrap) begin
						res_col_q <= '0;
						if (cur_row_q != ROW_MAX) begin
							res_row_q <= cur_row_q + ROW_W'(1);
						end
					end else begin
						res_col_q <= cur_col_q + COL_W'(1);
					end
				end
				ttc_pkg::ACT_SET: begin
					res_col_q <= clamp_col;
					res_row_q <= clamp_row;
				end
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_scroll_q, res_cell_q,
	                   ttc_pkg::OUT_ROW_W'(res_row_q), ttc_pkg::OUT_COL_W'(res_col_q)};

	// cursor never leaves the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_col_q} < (COL_W+1)'(COLUMNS)) && ({1'b0, cur_row_q} < (ROW_W+1)'(ROWS)))
		else $error("cursor outside screen");

	// a wrapping put on the last row starts the row copy
	a_scroll_start: assert property (@(posedge clk) disable iff (!arst_n)
		do_scroll |=> (state_q == ST_COPY) && (ptr_q == ROW_STEP))
		else $error("scroll did not start copy");

	// copy always ends in the bottom-row fill
	a_copy_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) && (ptr_q == LAST_CELL) |=>
		(state_q == ST_FILL) && (ptr_q == LAST_ROW0))
		else $error("copy did not hand over to fill");

	// read result is loaded when the RAM data arrives
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD2) |=> m_tvalid_q && !res_scroll_q)
		else $error("read result missing");

	// no item is taken while the store is being copied or cleared
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_from_rd_q || (state_q == ST_FILL)) |-> !accept)
		else $error("item accepted during store sweep");

endmodule

>>> design/ttc_screen_ram.sv
// ----------------------------------------------------------------------------
// ttc_screen_ram: character cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ttc_screen_ram #(
	parameter int DEPTH = ttc_pkg::COLUMNS_DEF * ttc_pkg::ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> bench/ttc_screen_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttc_screen_checker: scoreboard for the text console teletype
// Watches both stream channels, tracks its own copy of the screen and cursor,
// and compares every result item against the predicted cursor report.
// ----------------------------------------------------------------------------
module ttc_screen_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic [23:0] s_tdata,   // [7:0] char_code, [15:8] col_in, [23:16] row_in
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [6:0] cursor_col, [11:7] cursor_row,
	                               // [19:12] cell_char, [20] scrolled
	output int          mismatch_count,
	output int          outstanding
);

	localparam int CELLS = ttc_pkg::COLUMNS_DEF * ttc_pkg::ROWS_DEF;

	typedef struct packed {
		logic       scrolled;
		logic [7:0] cell_char;
		logic [4:0] row;
		logic [6:0] col;
	} cursor_report_t;

	logic [7:0]     screen [CELLS];
	logic [6:0]     col_q;
	logic [4:0]     row_q;
	cursor_report_t expected_reports [$];
	int             errors;

	function automatic int clamp_coord(logic [7:0] v, int lim);
		return (int'(v) >= lim) ? lim - 1 : int'(v);
	endfunction

	// updates the shadow screen and cursor, returns the report the block owes
	function cursor_report_t apply_action(logic [1:0] act, logic [7:0] ch,
	                                      logic [7:0] col_req, logic [7:0] row_req);
		cursor_report_t rep;
		int rc;
		int rr;
		int i;
		rep = '0;
		rc  = clamp_coord(col_req, ttc_pkg::COLUMNS_DEF);
		rr  = clamp_coord(row_req, ttc_pkg::ROWS_DEF);
		case (act)
			ttc_pkg::ACT_PUT: begin
				screen[int'(row_q) * ttc_pkg::COLUMNS_DEF + int'(col_q)] = ch;
				if (int'(col_q) == ttc_pkg::COLUMNS_DEF - 1) begin
					col_q = '0;
					if (int'(row_q) == ttc_pkg::ROWS_DEF - 1) begin
						for (i = 0; i < CELLS - ttc_pkg::COLUMNS_DEF; i++)
							screen[i] = screen[i + ttc_pkg::COLUMNS_DEF];
						for (i = CELLS - ttc_pkg::COLUMNS_DEF; i < CELLS; i++)
							screen[i] = ttc_pkg::BLANK_CHAR;
						rep.scrolled = 1'b1;
					end else begin
						row_q = row_q + 5'd1;
					end
				end else begin
					col_q = col_q + 7'd1;
				end
			end
			ttc_pkg::ACT_SET: begin
				col_q = rc[6:0];
				row_q = rr[4:0];
			end
			ttc_pkg::ACT_READ: begin
				rep.cell_char = screen[rr * ttc_pkg::COLUMNS_DEF + rc];
			end
			default: ;
		endcase
		rep.col = col_q;
		rep.row = row_q;
		return rep;
	endfunction

	function void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cursor_report_t got;
		cursor_report_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < CELLS; i++)
				screen[i] = ttc_pkg::BLANK_CHAR;
			col_q = '0;
			row_q = '0;
			expected_reports.delete();
			errors = 0;
		end else begin
			// results are registered and always trail their item, so pop first
			if (m_tvalid && m_tready) begin
				got = m_tdata[20:0];
				if (expected_reports.size() == 0) begin
					$display("%0t: result expected none got 0x%06h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_reports.pop_front();
					check_field("cursor_col", 8'(want.col), 8'(got.col));
					check_field("cursor_row", 8'(want.row), 8'(got.row));
					check_field("cell_char", want.cell_char, got.cell_char);
					check_field("scrolled", 8'(want.scrolled), 8'(got.scrolled));
				end
			end
			if (s_tvalid && s_tready)
				expected_reports.push_back(apply_action(s_tuser, s_tdata[7:0],
				                                        s_tdata[15:8], s_tdata[23:16]));
		end
		mismatch_count <= errors;
		outstanding    <= expected_reports.size();
	end

endmodule

>>> bench/text_console_teletype_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_teletype_core_tb: stimulus and verdict for the teletype core
// Directed put/set/read/scroll cases, then random action streams with
// random gaps and back-pressure; checking is done by ttc_screen_checker.
// ----------------------------------------------------------------------------
module text_console_teletype_core_tb;

	localparam logic [1:0] ACT_IDLE  = 2'd3;   // unused code, block only reports
	localparam int RANDOM_ITEMS      = 1950;
	localparam int STALL_LIMIT       = 20000;  // longer than a clear pass or a scroll
	localparam int TAIL_CYCLES       = 20;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [1:0]  s_tuser  = '0;
	logic [23:0] s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [23:0] m_tdata;

	int mismatch_count;
	int outstanding;
	int quiet_cycles = 0;
	int rx_hold      = 0;
	bit tx_eager     = 1'b0;
	bit rx_eager     = 1'b0;

	text_console_teletype_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ttc_screen_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tuser        (s_tuser),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: after each result item, may stall at random (never in eager mode)
	always @(posedge clk) begin
		int w;
		if (arst_n) begin
			if (m_tready && m_tvalid) begin
				w = rx_eager ? 0 : $urandom_range(0, 11);
				if (w == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					rx_hold  <= w;
				end
			end else if (!m_tready) begin
				if (rx_hold <= 1) begin
					m_tready <= 1'b1;
					rx_hold  <= 0;
				end else begin
					rx_hold <= rx_hold - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_action(logic [1:0] act, logic [7:0] ch,
	                           logic [7:0] col, logic [7:0] row);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {row, col, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);   // let the count catch up with the last item
		while (outstanding != 0) @(posedge clk);
	endtask

	// mostly on-screen, often near the far edge, sometimes anything
	function automatic logic [7:0] pick_coord(int lim);
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(0, 255));
			1:       return 8'($urandom_range(lim - 3, lim - 1));
			default: return 8'($urandom_range(0, lim - 1));
		endcase
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int sent;
		int r;
		int burst;
		bit paused;
		sent   = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		push_action(ttc_pkg::ACT_PUT,  8'h41, 8'd0, 8'd0);
		push_action(ttc_pkg::ACT_READ, any_byte(), 8'd0, 8'd0);
		push_action(ttc_pkg::ACT_READ, any_byte(), 8'd255, 8'd255);   // clamps to corner
		push_action(ttc_pkg::ACT_PUT,  8'h00, 8'd255, 8'd255);        // coords ignored by put
		push_action(ttc_pkg::ACT_PUT,  8'hFF, 8'd0, 8'd0);
		push_action(ttc_pkg::ACT_PUT,  8'h0A, 8'd0, 8'd0);  // newline is an ordinary byte
		push_action(ACT_IDLE, 8'hFF, 8'hFF, 8'hFF);
		push_action(ttc_pkg::ACT_SET,  8'hFF, 8'd255, 8'd255);
		push_action(ttc_pkg::ACT_PUT,  8'h55, 8'd0, 8'd0);            // last cell: scroll
		push_action(ttc_pkg::ACT_READ, 8'h00, 8'd79, 8'd23);
		push_action(ttc_pkg::ACT_READ, 8'h00, 8'd0, 8'd0);
		push_action(ttc_pkg::ACT_SET,  8'h00, 8'd79, 8'd0);
		push_action(ttc_pkg::ACT_PUT,  8'hAA, 8'd0, 8'd0);            // row wrap, no scroll
		push_action(ttc_pkg::ACT_READ, 8'hFF, 8'd79, 8'd0);
		push_action(ttc_pkg::ACT_SET,  8'h00, 8'd80, 8'd25);          // just past the edge
		push_action(ttc_pkg::ACT_SET,  8'h00, 8'd0, 8'd0);
		push_action(ttc_pkg::ACT_READ, 8'h00, 8'd0, 8'd255);
		push_action(ttc_pkg::ACT_SET,  8'h00, 8'd78, 8'd24);
		push_action(ttc_pkg::ACT_PUT,  8'h7E, 8'd0, 8'd0);
		push_action(ttc_pkg::ACT_PUT,  8'h81, 8'd0, 8'd0);            // scroll again
		push_action(ACT_IDLE, 8'h00, 8'h00, 8'h00);
		push_action(ttc_pkg::ACT_READ, 8'h00, 8'd79, 8'd23);

		// random part
		while (sent < RANDOM_ITEMS) begin
			if (sent % 150 == 0) begin
				tx_eager = ($urandom_range(0, 3) == 0);
				rx_eager = ($urandom_range(0, 3) == 0);
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_results_drained();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// run of text, sometimes long enough to cross a row end
				burst = $urandom_range(20, 90);
				repeat (burst)
					push_action(ttc_pkg::ACT_PUT, any_byte(), any_byte(), any_byte());
				sent += burst;
			end else begin
				if (r < 50)
					push_action(ttc_pkg::ACT_PUT, any_byte(), any_byte(), any_byte());
				else if (r < 70)
					push_action(ttc_pkg::ACT_SET, any_byte(),
					            pick_coord(ttc_pkg::COLUMNS_DEF),
					            pick_coord(ttc_pkg::ROWS_DEF));
				else if (r < 95)
					push_action(ttc_pkg::ACT_READ, any_byte(),
					            pick_coord(ttc_pkg::COLUMNS_DEF),
					            pick_coord(ttc_pkg::ROWS_DEF));
				else
					push_action(ACT_IDLE, any_byte(), any_byte(), any_byte());
				sent++;
			end
		end

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
